FILE: hdl/b2b_pkg.sv
// BLAKE2b engine package: IV, message schedule, G-function and byte helpers.
// Used by the hash engine top level and b2b_gunit; no dependencies.
`default_nettype none
package b2b_pkg;

  localparam int unsigned RoundsDefault = 12;

  typedef logic [63:0] word_t;

  localparam word_t IvTab [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t FinalMask = ~64'h0;

  localparam logic [3:0] SigmaTab [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  localparam logic [1:0] CfgDigestLen = 2'd0;
  localparam logic [1:0] CfgKeyLen    = 2'd1;

  // operands of one half of G: a += b + x; d = rotr(d ^ a, r1); c += d; b = rotr(b ^ c, r2)
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  // mask keeping the low n bytes (n = 0..8)
  function automatic word_t byte_mask(input logic [3:0] n);
    word_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[i*8 +: 8] = 8'hff;
    end
    byte_mask = m;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/blake2b_hash_engine.sv
// BLAKE2b hash engine top level: byte packer, block RAM, sequencer, digest out.
// Depends on b2b_pkg, b2b_ram, b2b_gunit.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  data    | in_valid_i/in_ready_o, data_word_i, ...   | in
//  digest  | out_valid_o/out_ready_i, digest_word_o .. | out
//  config  | cfg_valid_i/cfg_ready_o, cfg_index_i, ... | in
//
// A word that stays inside one buffer word passes accept, RAM read and merge
// write; one that straddles two buffer words repeats the read and merge write.
// A word that starts a new block first compresses the held block: one G half
// step per cycle on the single shared unit, 16 per round. The last word adds
// a final compression and one beat per digest word. Reset is asynchronous and
// gives the IV-based chain value. Output stalls hold the engine; no input is
// taken until all beats leave.
`default_nettype none
module blake2b_hash_engine
  import b2b_pkg::*;
#(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [63:0] digest_word_o,
  output logic      [2:0]  word_index_o,
  output logic             last_word_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  localparam int unsigned RW = $clog2(Rounds + 1);

  typedef enum logic [5:0] {
    StIdle  = 6'b00_0001,
    StRdA   = 6'b00_0010,  // read buffer word for merge
    StWrA   = 6'b00_0100,
    StInit  = 6'b00_1000,
    StRound = 6'b01_0000,
    StOut   = 6'b10_0000
  } state_e;

  state_e state_q, state_d;

  logic [6:0] dlen_q, klen_q;
  word_t h_q [8];
  word_t v_q [16];
  logic [7:0] nbuf_q;
  logic [63:0] cnt0_q, cnt1_q;

  // latched input beat
  word_t       wd_q;
  logic [3:0]  nb_q;
  logic        last_q;
  logic        fin_q;      // current compression is final
  logic        pend_q;     // compress before merging
  logic [RW-1:0] rnd_q;
  logic [3:0]  smod_q;     // round number mod 10
  logic [3:0]  step_q;     // half-step index in round (16)
  logic [2:0]  oidx_q;

  // ram
  logic        ram_we;
  logic [3:0]  ram_addr;
  logic [3:0]  raddr_q;    // address behind ram_rd
  word_t       ram_wd, ram_rd;

  b2b_ram #(.Width(64), .Depth(16)) u_buf (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // effective lengths
  logic [6:0] dl_eff, kl_eff;
  assign dl_eff = (dlen_q == 7'd0) ? 7'd1 : (dlen_q > 7'd64) ? 7'd64 : dlen_q;
  assign kl_eff = (klen_q > 7'd64) ? 7'd64 : klen_q;
  word_t pword;
  assign pword = {32'h0, 8'h01, 8'h01, 1'b0, kl_eff, 1'b0, dl_eff};
  logic [3:0] nwords;
  assign nwords = 4'((8'(dl_eff) + 8'd7) >> 3);

  // G operand selection: step 0..15 -> g = step>>1, half = step[0]
  logic [2:0] g_sel;
  logic       half;
  assign g_sel = step_q[3:1];
  assign half  = step_q[0];
  logic [3:0] ia, ib, ic, id;
  always_comb begin
    ia = {2'b00, g_sel[1:0]};
    if (!g_sel[2]) begin
      ib = {2'b01, g_sel[1:0]};
      ic = {2'b10, g_sel[1:0]};
      id = {2'b11, g_sel[1:0]};
    end else begin
      ib = {2'b01, 2'(g_sel[1:0] + 2'd1)};
      ic = {2'b10, 2'(g_sel[1:0] + 2'd2)};
      id = {2'b11, 2'(g_sel[1:0] + 2'd3)};
    end
  end

  // schedule: message index for next half step, read in the cycle before its use
  logic [RW-1:0] rnd_n;
  logic [3:0]    step_n;
  logic [3:0]    rmod;
  always_comb begin
    step_n = 4'(step_q + 4'd1);
    rnd_n  = (step_q == 4'd15) ? RW'(rnd_q + RW'(1)) : rnd_q;
    if (step_q != 4'd15) rmod = smod_q;
    else if (smod_q == 4'd9) rmod = 4'd0;
    else rmod = 4'(smod_q + 4'd1);
  end

  // zero-fill of tail happens on the fly: reads beyond nbuf are masked
  logic [7:0] wbase, wleft;
  word_t      m_word;
  assign wbase = {1'b0, raddr_q, 3'b000};
  assign wleft = 8'(nbuf_q - wbase);
  always_comb begin
    m_word = ram_rd;
    if (nbuf_q <= wbase) m_word = '0;
    else if (wleft < 8'd8) m_word = ram_rd & byte_mask(wleft[3:0]);
  end

  quad_t g_in, g_out;
  assign g_in = '{a: v_q[ia], b: v_q[ib], c: v_q[ic], d: v_q[id]};
  b2b_gunit u_g (.q_i(g_in), .m_i(m_word), .second_i(half), .q_o(g_out));

  // merge of input bytes into buffer
  logic [2:0]  boff;
  logic [3:0]  nb_sat;
  logic [3:0]  first_n;  // bytes landing in first word
  logic [7:0]  room;
  assign boff = nbuf_q[2:0];
  assign nb_sat = (nb_q > 4'd8) ? 4'd8 : nb_q;
  always_comb begin
    first_n = 4'(4'd8 - {1'b0, boff});
    if (first_n > nb_sat) first_n = nb_sat;
  end
  assign room = 8'(8'd128 - nbuf_q);
  word_t shifted, keep_m;
  assign shifted = (wd_q & byte_mask(nb_sat)) << {boff, 3'b000};
  assign keep_m  = ~(byte_mask(nb_sat) << {boff, 3'b000});

  logic cfg_fire, in_fire;
  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign in_fire  = in_valid_i && in_ready_o && !cfg_fire;

  assign out_valid_o = (state_q == StOut);
  always_comb begin
    word_t d;
    logic [6:0] rem;
    d = h_q[oidx_q];
    rem = 7'(dl_eff - {1'b0, oidx_q, 3'b000});
    if (rem < 7'd8) d = d & byte_mask(rem[3:0]);
    digest_word_o = d;
  end
  assign word_index_o = oidx_q;
  assign last_word_o  = (4'(oidx_q) + 4'd1 == nwords);

  always_comb begin
    state_d  = state_q;
    ram_we   = 1'b0;
    ram_addr = nbuf_q[6:3];
    ram_wd   = '0;
    case (state_q)
      StIdle:  if (in_fire) state_d = StRdA;
      StRdA: begin
        if (nb_sat != 4'd0 && nbuf_q == 8'd128 && !pend_q) state_d = StInit;
        else if (nb_sat == 4'd0 || room == 8'd0) begin
          state_d = last_q ? StInit : StIdle;
        end else state_d = StWrA;
      end
      StWrA: begin
        ram_we = 1'b1;
        ram_wd = (ram_rd & keep_m) | shifted;
        // remaining bytes go round again, after a compression if the block filled
        state_d = (first_n < nb_sat) ? StRdA : (last_q ? StInit : StIdle);
      end
      StInit: begin
        ram_addr = SigmaTab[0][0];
        state_d = StRound;
      end
      StRound: begin
        ram_addr = SigmaTab[rmod][step_n];
        if (step_q == 4'd15 && rnd_q == RW'(Rounds - 1)) begin
          state_d = fin_q ? StOut : StRdA;
        end
      end
      StOut: if (out_ready_i && last_word_o) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // v including the last G's fresh outputs
  function automatic word_t g_x(input logic [3:0] k);
    word_t r;
    r = v_q[k];
    if (k == ia) r = g_out.a;
    if (k == ib) r = g_out.b;
    if (k == ic) r = g_out.c;
    if (k == id) r = g_out.d;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dlen_q  <= 7'd64;
      klen_q  <= 7'd0;
      for (int i = 1; i < 8; i++) h_q[i] <= IvTab[i];
      h_q[0]  <= IvTab[0] ^ 64'h0101_0040;
      nbuf_q  <= '0;
      cnt0_q  <= '0;
      cnt1_q  <= '0;
      pend_q  <= 1'b0;
      fin_q   <= 1'b0;
      rnd_q   <= '0;
      smod_q  <= '0;
      step_q  <= '0;
      oidx_q  <= '0;
      raddr_q <= '0;
    end else begin
      state_q <= state_d;
      raddr_q <= ram_addr;
      if (cfg_fire && (cfg_index_i == CfgDigestLen || cfg_index_i == CfgKeyLen)) begin
        logic [6:0] dn, kn;
        word_t pw;
        dn = (cfg_index_i == CfgDigestLen) ? cfg_data_i[6:0] : dlen_q;
        kn = (cfg_index_i == CfgKeyLen) ? cfg_data_i[6:0] : klen_q;
        dlen_q <= dn;
        klen_q <= kn;
        dn = (dn == 7'd0) ? 7'd1 : (dn > 7'd64) ? 7'd64 : dn;
        kn = (kn > 7'd64) ? 7'd64 : kn;
        pw = {32'h0, 8'h01, 8'h01, 1'b0, kn, 1'b0, dn};
        for (int i = 1; i < 8; i++) h_q[i] <= IvTab[i];
        h_q[0] <= IvTab[0] ^ pw;
        nbuf_q <= '0;
        cnt0_q <= '0;
        cnt1_q <= '0;
      end
      case (state_q)
        StIdle: if (in_fire) begin
          wd_q   <= data_word_i;
          nb_q   <= valid_bytes_i;
          last_q <= is_last_i;
          pend_q <= 1'b0;
          fin_q  <= 1'b0;
        end
        StRdA: begin
          if (nb_sat != 4'd0 && nbuf_q == 8'd128 && !pend_q) begin
            {cnt1_q, cnt0_q} <= {cnt1_q, cnt0_q} + 128'd128;
            fin_q  <= 1'b0;
            pend_q <= 1'b1;
          end else if (last_q && !(nb_sat != 4'd0 && room != 8'd0)) begin
            {cnt1_q, cnt0_q} <= {cnt1_q, cnt0_q} + {120'h0, nbuf_q};
            fin_q <= 1'b1;
          end
        end
        StWrA: begin
          nbuf_q <= 8'(nbuf_q + {4'h0, first_n});
          if (first_n < nb_sat) begin
            wd_q <= wd_q >> {first_n, 3'b000};
            nb_q <= 4'(nb_sat - first_n);
          end else if (last_q) begin
            {cnt1_q, cnt0_q} <= {cnt1_q, cnt0_q} + {120'h0, 8'(nbuf_q + {4'h0, first_n})};
            fin_q <= 1'b1;
          end
        end
        StInit: begin
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          for (int i = 0; i < 4; i++) v_q[i+8] <= IvTab[i];
          v_q[12] <= IvTab[4] ^ cnt0_q;
          v_q[13] <= IvTab[5] ^ cnt1_q;
          v_q[14] <= fin_q ? (IvTab[6] ^ FinalMask) : IvTab[6];
          v_q[15] <= IvTab[7];
          rnd_q  <= '0;
          smod_q <= '0;
          step_q <= '0;
        end
        StRound: begin
          v_q[ia] <= g_out.a;
          v_q[ib] <= g_out.b;
          v_q[ic] <= g_out.c;
          v_q[id] <= g_out.d;
          step_q  <= step_n;
          rnd_q   <= rnd_n;
          smod_q  <= rmod;
          if (step_q == 4'd15 && rnd_q == RW'(Rounds - 1)) begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ g_x(4'(i)) ^ g_x(4'(i + 8));
            if (!fin_q) nbuf_q <= '0;
            oidx_q <= '0;
          end
        end
        StOut: if (out_ready_i) begin
          oidx_q <= 3'(oidx_q + 3'd1);
          if (last_word_o) begin
            for (int i = 1; i < 8; i++) h_q[i] <= IvTab[i];
            h_q[0] <= IvTab[0] ^ pword;
            nbuf_q <= '0;
            cnt0_q <= '0;
            cnt1_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/b2b_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none
module b2b_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: hdl/b2b_gunit.sv
// Shared half-G unit: three adds, two xors and two rotates for one G half step.
// Depends on b2b_pkg.
`default_nettype none
module b2b_gunit
  import b2b_pkg::*;
(
  input  wire quad_t      q_i,
  input  wire word_t      m_i,
  input  wire logic       second_i,
  output quad_t           q_o
);
  word_t a_n, d_n, c_n, b_n;

  always_comb begin
    a_n = q_i.a + q_i.b + m_i;
    d_n = second_i ? rotr(q_i.d ^ a_n, 16) : rotr(q_i.d ^ a_n, 32);
    c_n = q_i.c + d_n;
    b_n = second_i ? rotr(q_i.b ^ c_n, 63) : rotr(q_i.b ^ c_n, 24);
    q_o = '{a: a_n, b: b_n, c: c_n, d: d_n};
  end
endmodule
`default_nettype wire

FILE: bench/blake2b_hash_engine_test.sv
// Self-checking bench for blake2b_hash_engine: streams messages, predicts digests
// with an in-bench BLAKE2b model and scores every output beat. Uses b2b_pkg.
`timescale 1ns / 100ps
module blake2b_hash_engine_test;
  import b2b_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned WordTarget = 260;

  typedef struct {
    word_t      dword;
    logic [2:0] idx;
    logic       fin;
  } digest_beat_t;

  class digest_board;
    word_t        chain[8];
    logic [7:0]   blk[128];
    int unsigned  fill;
    logic [127:0] total;
    logic [6:0]   dlen;
    logic [6:0]   klen;
    word_t        vw[16];
    digest_beat_t pending[$];
    int unsigned  errors;
    int unsigned  beats_seen;
    int unsigned  digests;

    function new();
      dlen = 7'd64;
      klen = 7'd0;
      errors = 0;
      beats_seen = 0;
      digests = 0;
      restart();
    endfunction

    function int unsigned eff_dlen();
      if (dlen == 0) return 1;
      if (dlen > 64) return 64;
      return dlen;
    endfunction

    function void restart();
      word_t pw;
      int unsigned kl;
      kl = (klen > 64) ? 64 : klen;
      pw = word_t'(eff_dlen()) | (word_t'(kl) << 8) | (64'd1 << 16) | (64'd1 << 24);
      for (int i = 0; i < 8; i++) chain[i] = IvTab[i];
      chain[0] ^= pw;
      fill = 0;
      total = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      if (idx == CfgDigestLen) dlen = val[6:0];
      else if (idx == CfgKeyLen) klen = val[6:0];
      else return;
      restart();
    endfunction

    function word_t ror(word_t x, int unsigned n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void mix(int a, int b, int c, int d, word_t x, word_t y);
      vw[a] = vw[a] + vw[b] + x; vw[d] = ror(vw[d] ^ vw[a], 32);
      vw[c] = vw[c] + vw[d];     vw[b] = ror(vw[b] ^ vw[c], 24);
      vw[a] = vw[a] + vw[b] + y; vw[d] = ror(vw[d] ^ vw[a], 16);
      vw[c] = vw[c] + vw[d];     vw[b] = ror(vw[b] ^ vw[c], 63);
    endfunction

    function void compress(bit last_blk);
      word_t m[16];
      int s;
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 8; j++) m[i][j*8 +: 8] = blk[i*8 + j];
      end
      for (int i = 0; i < 8; i++) begin
        vw[i] = chain[i];
        vw[i+8] = IvTab[i];
      end
      vw[12] ^= total[63:0];
      vw[13] ^= total[127:64];
      if (last_blk) vw[14] ^= FinalMask;
      for (int r = 0; r < 12; r++) begin
        s = r % 10;
        mix(0, 4,  8, 12, m[SigmaTab[s][0]],  m[SigmaTab[s][1]]);
        mix(1, 5,  9, 13, m[SigmaTab[s][2]],  m[SigmaTab[s][3]]);
        mix(2, 6, 10, 14, m[SigmaTab[s][4]],  m[SigmaTab[s][5]]);
        mix(3, 7, 11, 15, m[SigmaTab[s][6]],  m[SigmaTab[s][7]]);
        mix(0, 5, 10, 15, m[SigmaTab[s][8]],  m[SigmaTab[s][9]]);
        mix(1, 6, 11, 12, m[SigmaTab[s][10]], m[SigmaTab[s][11]]);
        mix(2, 7,  8, 13, m[SigmaTab[s][12]], m[SigmaTab[s][13]]);
        mix(3, 4,  9, 14, m[SigmaTab[s][14]], m[SigmaTab[s][15]]);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= vw[i] ^ vw[i+8];
    endfunction

    // one accepted input beat: pack bytes, on the last word queue the digest
    function void note_word(word_t data, logic [3:0] nb, logic lst);
      int unsigned n, dl, nw, rem;
      digest_beat_t e;
      n = (nb > 8) ? 8 : nb;
      for (int i = 0; i < n; i++) begin
        if (fill >= 128) begin
          total += 128;
          compress(0);
          fill = 0;
        end
        blk[fill] = data[i*8 +: 8];
        fill++;
      end
      if (!lst) return;
      total += fill;
      for (int p = fill; p < 128; p++) blk[p] = 8'h00;
      compress(1);
      dl = eff_dlen();
      nw = (dl + 7) / 8;
      for (int i = 0; i < nw; i++) begin
        e.dword = chain[i];
        rem = dl - 8 * i;
        if (rem < 8) e.dword &= (64'd1 << (8 * rem)) - 64'd1;
        e.idx = 3'(i);
        e.fin = (i + 1 == nw);
        pending.push_back(e);
      end
      digests++;
      restart();
    endfunction

    function void check_beat(word_t dw, logic [2:0] idx, logic fin);
      digest_beat_t e;
      beats_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest beat: word %h index %0d", dw, idx);
        return;
      end
      e = pending.pop_front();
      if (e.dword !== dw || e.idx !== idx || e.fin !== fin) begin
        errors++;
        if (errors <= 10)
          $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                   e.dword, e.idx, e.fin, dw, idx, fin);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  blake2b_hash_engine DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  digest_board board = new();
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern: stall_mode picks one of four ready patterns and is redrawn at random
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= (stall_tick % 3 == 0);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_beat(digest_word_o, word_index_o, last_word_o);
  end

  // called at a falling edge; leaves valid high until a gap is due
  task automatic send_word(word_t data, logic [3:0] nb, logic lst);
    in_valid_i = 1'b1;
    data_word_i = data;
    valid_bytes_i = nb;
    is_last_i = lst;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(data, nb, lst);
    words_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic go_idle();
    in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    go_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // message of body_words non-last words, random content
  task automatic send_message(int unsigned body_words, logic [3:0] tail_nb);
    logic [3:0] nb;
    for (int i = 0; i < body_words; i++) begin
      nb = 4'd8;
      if ($urandom_range(0, 9) == 0) nb = 4'($urandom_range(0, 15));
      send_word(rand_word(), nb, 1'b0);
    end
    send_word(rand_word(), tail_nb, 1'b1);
  endtask

  initial begin
    int unsigned len;
    logic [3:0] tail;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty, field extremes, oversized count, unaligned partial, full block
    send_word(64'h0, 4'd0, 1'b1);
    send_word(~64'h0, 4'd8, 1'b1);
    send_word(64'h0, 4'd15, 1'b1);
    send_word(64'h0123456789abcdef, 4'd3, 1'b0);
    send_word(~64'h0, 4'd8, 1'b0);
    send_word(64'hfedcba9876543210, 4'd5, 1'b1);
    for (int i = 0; i < 15; i++) send_word(rand_word(), 4'd8, 1'b0);
    send_word(rand_word(), 4'd8, 1'b1);

    cfg_write(CfgDigestLen, 64'd1);
    cfg_write(CfgKeyLen, 64'd64);
    send_message(3, 4'd8);
    cfg_write(CfgDigestLen, 64'd0);
    cfg_write(CfgKeyLen, 64'd127);
    send_message(1, 4'd0);
    cfg_write(CfgDigestLen, ~64'h0);
    cfg_write(2'd3, 64'd5);
    send_message(0, 4'd9);

    // random: mostly short messages, some across several blocks
    while (words_sent < WordTarget) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1)) cfg_write(CfgDigestLen, 64'($urandom_range(0, 127)));
        else cfg_write(CfgDigestLen, 64'($urandom_range(1, 64)));
        cfg_write(CfgKeyLen, 64'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 127 : 64)));
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 8);
      tail = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      send_message(len, tail);
    end

    in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("covered %0d input words, %0d digests, %0d digest beats",
             words_sent, board.digests, board.beats_seen);
    $display("mismatches or stray beats: %0d", board.errors);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
